/* src/tmbl_pkg.sv */
// Shared types and constants for the torque map bilinear lookup.
// Depends on nothing; used by the top level and the dv files.
`default_nettype none

package tmbl_pkg;

  // fixed field widths
  localparam int unsigned VOLT_W     = 10;
  localparam int unsigned SPEED_W    = 14;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned TQ_W       = 12;
  localparam int unsigned TQ_MAX     = (2 ** TQ_W) - 1;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // register reset values
  localparam logic [VOLT_W-1:0]  VOLTAGE_BASE_RST = VOLT_W'(280);
  localparam logic [SPEED_W-1:0] SPEED_BASE_RST   = SPEED_W'(2000);

  // register index, taken from the word address
  typedef enum logic [0:0] {
    REG_VOLTAGE_BASE = 1'b0,
    REG_SPEED_BASE   = 1'b1
  } cfg_reg_e;

  // item kind
  typedef enum logic [0:0] {
    ACT_QUERY = 1'b0,
    ACT_LOAD  = 1'b1
  } action_e;

  // pipeline occupancy, one per stage
  typedef struct packed {
    logic valid;
    logic load;
  } ctl_t;

  // load payload and clamp flags carried to the memory stage
  typedef struct packed {
    logic [IDX_W-1:0] entry_row;
    logic [IDX_W-1:0] entry_column;
    logic [TQ_W-1:0]  entry_value;
    logic             top_v;
    logic             top_s;
  } front_t;

endpackage

`default_nettype wire

/* src/tmbl_cdiv.sv */
// Pipelined divide of an unsigned value by a constant: reciprocal multiply,
// back multiply and one correction step. Three register stages, no package use.
`default_nettype none

module tmbl_cdiv #(
  parameter int unsigned IN_W    = 10,
  parameter int unsigned DIVISOR = 5,
  parameter int unsigned Q_W     = 5,
  parameter int unsigned REM_W   = 3
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [IN_W-1:0]  dividend_i,
  output logic [Q_W-1:0]   quot_o,
  output logic [REM_W-1:0] rem_o
);

  localparam int unsigned RECIP = (2 ** IN_W) / DIVISOR;
  localparam int unsigned R_W   = $clog2(RECIP + 1);
  localparam int unsigned D_W   = $clog2(DIVISOR + 1);
  localparam int unsigned DR_W  = D_W + 1;
  localparam int unsigned P_W   = IN_W + R_W;
  localparam int unsigned BK_W  = R_W + D_W;

  localparam logic [R_W-1:0]  RECIP_V = R_W'(RECIP);
  localparam logic [DR_W-1:0] DIV_V   = DR_W'(DIVISOR);

  logic [P_W-1:0]  prod_q;
  logic [IN_W-1:0] dvd_q;
  logic [R_W-1:0]  qest;
  logic [BK_W-1:0] back;
  logic [IN_W-1:0] diff;
  logic [R_W-1:0]  qest_q;
  logic [DR_W-1:0] rest_q;
  logic [R_W-1:0]  quot_d, quot_q;
  logic [DR_W-1:0] rem_d, rem_q;

  // stage a: estimate from the floor reciprocal, never above the true quotient
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= P_W'(dividend_i) * P_W'(RECIP_V);
      dvd_q  <= dividend_i;
    end
  end

  // stage b: remainder of the estimate, below twice the divisor
  assign qest = prod_q[P_W-1:IN_W];
  assign back = BK_W'(qest) * BK_W'(DIV_V);
  assign diff = dvd_q - IN_W'(back);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      qest_q <= qest;
      rest_q <= diff[DR_W-1:0];
    end
  end

  // stage c: single correction
  always_comb begin
    if (rest_q >= DIV_V) begin
      quot_d = qest_q + R_W'(1);
      rem_d  = rest_q - DIV_V;
    end else begin
      quot_d = qest_q;
      rem_d  = rest_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign quot_o = Q_W'(quot_q);
  assign rem_o  = REM_W'(rem_q);

endmodule

`default_nettype wire

/* src/torque_map_bilinear_lookup.sv */
// Top level of the torque map bilinear lookup: grid banks and lookup pipeline.
// Depends on tmbl_pkg and tmbl_cdiv.
//
// Usage
//   Input channel (in_valid_i / in_stall_o) carries one transaction per item.
//   action_i = load writes entry_value_i into grid entry (entry_row_i,
//   entry_column_i) and returns nothing; out-of-range indexes are dropped.
//   action_i = query returns one torque_o on the output channel
//   (out_valid_o / out_stall_i), bilinear over the four surrounding entries.
//   Throughput: one transaction per cycle unless out_stall_i holds the
//   pipeline, loads and queries mixed freely. The grid sits in four
//   single-port-read memories split by row and column parity, so the
//   four corners of a query are read in the same cycle. The offset
//   register, the three-stage locate divider, the bank read, the weight,
//   product and sum registers and the three-stage divide of the weighted
//   sum make eleven register stages.
//   Loads write the banks at the same stage where queries read them, so
//   item order is kept without forwarding.
//   Reset clears the pipeline and sets voltage_base to 280 and speed_base to
//   2000; grid contents are undefined and every entry must be loaded first.
//   While a result waits under out_stall_i the whole pipeline holds and
//   in_stall_o is raised in the same cycle.
`default_nettype none

module torque_map_bilinear_lookup #(
  parameter int unsigned GRID_ROWS  = 26,
  parameter int unsigned GRID_COLS  = 26,
  parameter int unsigned VOLT_STEP  = 5,
  parameter int unsigned SPEED_STEP = 160
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tmbl_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [tmbl_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [tmbl_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                action_i,
  input  logic [tmbl_pkg::VOLT_W-1:0]         voltage_i,
  input  logic [tmbl_pkg::SPEED_W-1:0]        speed_i,
  input  logic [tmbl_pkg::IDX_W-1:0]          entry_row_i,
  input  logic [tmbl_pkg::IDX_W-1:0]          entry_column_i,
  input  logic [tmbl_pkg::TQ_W-1:0]           entry_value_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [tmbl_pkg::TQ_W-1:0]           torque_o
);

  localparam int unsigned TQ_W       = tmbl_pkg::TQ_W;
  localparam int unsigned ROW_W      = $clog2(GRID_ROWS);
  localparam int unsigned COL_W      = $clog2(GRID_COLS);
  localparam int unsigned VLO_W      = $clog2(VOLT_STEP + 1);
  localparam int unsigned SLO_W      = $clog2(SPEED_STEP + 1);
  localparam int unsigned W_W        = VLO_W + SLO_W;
  localparam int unsigned P_W        = TQ_W + W_W;
  localparam int unsigned CELL_DIV   = VOLT_STEP * SPEED_STEP;
  localparam int unsigned SUM_W      = $clog2(tmbl_pkg::TQ_MAX * CELL_DIV + 1);
  localparam int unsigned QR_W       = $clog2(CELL_DIV + 1);
  localparam int unsigned LAST_V     = (GRID_COLS - 1) * VOLT_STEP;
  localparam int unsigned LAST_S     = (GRID_ROWS - 1) * SPEED_STEP;
  localparam int unsigned HALF_R     = (GRID_ROWS + 1) / 2;
  localparam int unsigned HALF_C     = (GRID_COLS + 1) / 2;
  localparam int unsigned BANK_DEPTH = HALF_R * HALF_C;
  localparam int unsigned BA_W       = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
  localparam int unsigned NSTG       = 11;

  // ---------------------------------------------------------------------
  // configuration registers
  logic [tmbl_pkg::VOLT_W-1:0]  vbase_q;
  logic [tmbl_pkg::SPEED_W-1:0] sbase_q;
  tmbl_pkg::cfg_reg_e           reg_sel;
  logic                         cfg_wr;

  assign pready  = 1'b1;
  assign reg_sel = tmbl_pkg::cfg_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vbase_q <= tmbl_pkg::VOLTAGE_BASE_RST;
      sbase_q <= tmbl_pkg::SPEED_BASE_RST;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        tmbl_pkg::REG_VOLTAGE_BASE: vbase_q <= pwdata[tmbl_pkg::VOLT_W-1:0];
        tmbl_pkg::REG_SPEED_BASE:   sbase_q <= pwdata[tmbl_pkg::SPEED_W-1:0];
        default:                    vbase_q <= vbase_q;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_sel)
      tmbl_pkg::REG_VOLTAGE_BASE: prdata = tmbl_pkg::CFG_DATA_W'(vbase_q);
      tmbl_pkg::REG_SPEED_BASE:   prdata = tmbl_pkg::CFG_DATA_W'(sbase_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // pipeline advance: hold everything while a result waits under stall
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  tmbl_pkg::ctl_t   ctl_q [1:NSTG];
  tmbl_pkg::front_t fr_q  [1:4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 1; k <= NSTG; k++) begin
        ctl_q[k] <= '0;
      end
    end else if (adv) begin
      ctl_q[1].valid <= in_valid_i;
      ctl_q[1].load  <= (action_i == tmbl_pkg::ACT_LOAD);
      for (int k = 2; k <= NSTG; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: offsets from the grid base, clamped below, top-edge flags
  logic [tmbl_pkg::VOLT_W-1:0]  off_v, off_v_q;
  logic [tmbl_pkg::SPEED_W-1:0] off_s, off_s_q;
  logic                         top_v, top_s;

  assign off_v = (voltage_i > vbase_q) ? (voltage_i - vbase_q) : '0;
  assign off_s = (speed_i > sbase_q) ? (speed_i - sbase_q) : '0;
  assign top_v = (32'(off_v) >= LAST_V);
  assign top_s = (32'(off_s) >= LAST_S);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      off_v_q <= off_v;
      off_s_q <= off_s;
      fr_q[1] <= '{entry_row:    entry_row_i,
                   entry_column: entry_column_i,
                   entry_value:  entry_value_i,
                   top_v:        top_v,
                   top_s:        top_s};
      for (int k = 2; k <= 4; k++) begin
        fr_q[k] <= fr_q[k-1];
      end
    end
  end

  // stages 2..4: floor cell and distance above it
  logic [COL_W-1:0] q_col;
  logic [VLO_W-1:0] r_vlo;
  logic [ROW_W-1:0] q_row;
  logic [SLO_W-1:0] r_slo;

  tmbl_cdiv #(
    .IN_W    (tmbl_pkg::VOLT_W),
    .DIVISOR (VOLT_STEP),
    .Q_W     (COL_W),
    .REM_W   (VLO_W)
  ) u_loc_volt (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (off_v_q),
    .quot_o     (q_col),
    .rem_o      (r_vlo)
  );

  tmbl_cdiv #(
    .IN_W    (tmbl_pkg::SPEED_W),
    .DIVISOR (SPEED_STEP),
    .Q_W     (ROW_W),
    .REM_W   (SLO_W)
  ) u_loc_speed (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (off_s_q),
    .quot_o     (q_row),
    .rem_o      (r_slo)
  );

  // ---------------------------------------------------------------------
  // stage 4: top clamp, bank addressing, load writes and corner reads
  logic [COL_W-1:0] col_c;
  logic [ROW_W-1:0] row_c;
  logic [VLO_W-1:0] vlo_c;
  logic [SLO_W-1:0] slo_c;

  assign col_c = fr_q[4].top_v ? COL_W'(GRID_COLS - 2) : q_col;
  assign vlo_c = fr_q[4].top_v ? VLO_W'(VOLT_STEP) : r_vlo;
  assign row_c = fr_q[4].top_s ? ROW_W'(GRID_ROWS - 2) : q_row;
  assign slo_c = fr_q[4].top_s ? SLO_W'(SPEED_STEP) : r_slo;

  // entry (r, c) lives in bank {r[0], c[0]} at row-major half index
  function automatic logic [BA_W-1:0] bank_addr(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return BA_W'(r >> 1) * BA_W'(HALF_C) + BA_W'(c >> 1);
  endfunction

  logic             ld_in_range;
  logic             ld_ok;
  logic [ROW_W-1:0] wr_row;
  logic [COL_W-1:0] wr_col;
  logic [BA_W-1:0]  wr_addr;
  logic [3:0]       bank_we;
  logic [TQ_W-1:0]  rd_q [4];

  assign ld_in_range = (32'(fr_q[4].entry_row) < GRID_ROWS) &&
                       (32'(fr_q[4].entry_column) < GRID_COLS);
  assign ld_ok   = adv && ctl_q[4].valid && ctl_q[4].load && ld_in_range;
  assign wr_row  = ROW_W'(fr_q[4].entry_row);
  assign wr_col  = COL_W'(fr_q[4].entry_column);
  assign wr_addr = bank_addr(wr_row, wr_col);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    localparam logic PR = 1'((b / 2) % 2);
    localparam logic PC = 1'(b % 2);

    logic [TQ_W-1:0]  mem [BANK_DEPTH];
    logic [ROW_W-1:0] rd_row;
    logic [COL_W-1:0] rd_col;

    // the corner of this parity is the floor point or the next one
    assign rd_row     = (row_c[0] == PR) ? row_c : (row_c + ROW_W'(1));
    assign rd_col     = (col_c[0] == PC) ? col_c : (col_c + COL_W'(1));
    assign bank_we[b] = ld_ok && (wr_row[0] == PR) && (wr_col[0] == PC);

    always_ff @(posedge clk_i) begin
      if (bank_we[b]) begin
        mem[wr_addr] <= fr_q[4].entry_value;
      end
      if (adv) begin
        rd_q[b] <= mem[bank_addr(rd_row, rd_col)];
      end
    end
  end

  logic [VLO_W-1:0] vlo_q;
  logic [SLO_W-1:0] slo_q;
  logic             rpar_q, cpar_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vlo_q  <= vlo_c;
      slo_q  <= slo_c;
      rpar_q <= row_c[0];
      cpar_q <= col_c[0];
    end
  end

  // ---------------------------------------------------------------------
  // stage 5: route banks to corners, opposite-distance weights
  // corner k: bit 1 picks row + 1, bit 0 picks column + 1
  logic [VLO_W-1:0] vhi;
  logic [SLO_W-1:0] shi;
  logic [TQ_W-1:0]  sel1   [4];
  logic [TQ_W-1:0]  corner [4];
  logic [W_W-1:0]   wgt    [4];
  logic [TQ_W-1:0]  corner_q [4];
  logic [W_W-1:0]   w_q      [4];

  assign vhi = VLO_W'(VOLT_STEP) - vlo_q;
  assign shi = SLO_W'(SPEED_STEP) - slo_q;

  for (genvar k = 0; k < 4; k++) begin : g_corner
    localparam int unsigned DR = (k / 2) % 2;
    localparam int unsigned DC = k % 2;

    logic [SLO_W-1:0] rowf;
    logic [VLO_W-1:0] colf;

    assign sel1[k]   = cpar_q ? rd_q[k ^ 1] : rd_q[k];
    assign corner[k] = rpar_q ? sel1[k ^ 2] : sel1[k];
    assign rowf      = (DR == 1) ? slo_q : shi;
    assign colf      = (DC == 1) ? vlo_q : vhi;
    assign wgt[k]    = W_W'(rowf) * W_W'(colf);

    always_ff @(posedge clk_i) begin
      if (adv) begin
        corner_q[k] <= corner[k];
        w_q[k]      <= wgt[k];
      end
    end
  end

  // stage 6: weighted corners
  logic [P_W-1:0] prod_q [4];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 4; k++) begin
        prod_q[k] <= P_W'(corner_q[k]) * P_W'(w_q[k]);
      end
    end
  end

  // stage 7: sum of the four weighted corners
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sum_q <= SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) +
               SUM_W'(prod_q[2]) + SUM_W'(prod_q[3]);
    end
  end

  // stages 8..11: divide by the cell area, result register feeds the port
  logic [QR_W-1:0] area_rem;

  tmbl_cdiv #(
    .IN_W    (SUM_W),
    .DIVISOR (CELL_DIV),
    .Q_W     (TQ_W),
    .REM_W   (QR_W)
  ) u_area_div (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (sum_q),
    .quot_o     (torque_o),
    .rem_o      (area_rem)
  );

  assign out_valid_o = ctl_q[NSTG].valid && !ctl_q[NSTG].load;

  // ---------------------------------------------------------------------
  // assertions
  a_bank_we_onehot0 : assert property (
    @(posedge clk_i) disable iff (!rst_ni) $onehot0(bank_we)
  ) else $error("more than one grid bank written in a cycle");

  a_load_writes_once : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv && ctl_q[4].valid && ctl_q[4].load && ld_in_range |-> $onehot(bank_we)
  ) else $error("in-range load did not write exactly one bank");

  a_dist_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctl_q[5].valid && !ctl_q[5].load |->
      (32'(vlo_q) <= VOLT_STEP) && (32'(slo_q) <= SPEED_STEP)
  ) else $error("grid distance beyond one step");

  a_weight_sum : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    ctl_q[6].valid && !ctl_q[6].load |->
      (32'(w_q[0]) + 32'(w_q[1]) + 32'(w_q[2]) + 32'(w_q[3])) == CELL_DIV
  ) else $error("corner weights do not add up to the cell area");

  a_area_rem_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(area_rem) < CELL_DIV)
  ) else $error("area divide remainder not below the cell area");

endmodule

`default_nettype wire

/* dv/torque_map_bilinear_lookup_checker.sv */
// Checker for the torque map bilinear lookup: watches the config port and both channels,
// predicts each query's torque from its own grid copy and compares in order.
// Depends on tmbl_pkg.
module torque_map_bilinear_lookup_checker
  import tmbl_pkg::*;
#(
  parameter int unsigned GRID_ROWS  = 26,
  parameter int unsigned GRID_COLS  = 26,
  parameter int unsigned VOLT_STEP  = 5,
  parameter int unsigned SPEED_STEP = 160
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  input  logic [CFG_DATA_W-1:0] prdata,
  input  logic                  pready,
  // input channel
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  action_i,
  input  logic [VOLT_W-1:0]     voltage_i,
  input  logic [SPEED_W-1:0]    speed_i,
  input  logic [IDX_W-1:0]      entry_row_i,
  input  logic [IDX_W-1:0]      entry_column_i,
  input  logic [TQ_W-1:0]       entry_value_i,
  // output channel
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [TQ_W-1:0]       torque_i,
  // status for the test top
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  logic [TQ_W-1:0]    torque_grid_q [GRID_ROWS*GRID_COLS];
  logic [VOLT_W-1:0]  voltage_base_q;
  logic [SPEED_W-1:0] speed_base_q;
  logic [TQ_W-1:0]    torque_due_q [$];

  // floor cell and distance above it, clamped to the grid edges
  function automatic void grid_position(input int unsigned x, input int unsigned base,
                                        input int unsigned step, input int unsigned points,
                                        output int unsigned floor_idx,
                                        output int unsigned lower);
    int unsigned off;
    int unsigned last;
    off  = (x > base) ? (x - base) : 0;
    last = (points - 1) * step;
    if (off >= last) begin
      floor_idx = points - 2;
      lower     = step;
    end else begin
      floor_idx = off / step;
      lower     = off % step;
    end
  endfunction

  function automatic longint unsigned grid_entry(input int unsigned row, input int unsigned col);
    return longint'(torque_grid_q[row*GRID_COLS + col]);
  endfunction

  // weighted sum of the four corners over the cell area
  function automatic logic [TQ_W-1:0] interpolate_torque(input logic [VOLT_W-1:0] voltage,
                                                         input logic [SPEED_W-1:0] speed);
    int unsigned col, row, vlo, slo, vhi, shi;
    longint unsigned weighted;
    grid_position(voltage, voltage_base_q, VOLT_STEP, GRID_COLS, col, vlo);
    grid_position(speed, speed_base_q, SPEED_STEP, GRID_ROWS, row, slo);
    vhi = VOLT_STEP - vlo;
    shi = SPEED_STEP - slo;
    weighted = grid_entry(row, col) * vhi * shi
             + grid_entry(row + 1, col) * vhi * slo
             + grid_entry(row, col + 1) * vlo * shi
             + grid_entry(row + 1, col + 1) * vlo * slo;
    return TQ_W'(weighted / (VOLT_STEP * SPEED_STEP));
  endfunction

  always @(posedge clk_i) begin
    logic [TQ_W-1:0]       due;
    logic [CFG_DATA_W-1:0] reg_value;
    int unsigned           fails;
    fails = fail_count_o;
    if (!rst_ni) begin
      voltage_base_q <= VOLTAGE_BASE_RST;
      speed_base_q   <= SPEED_BASE_RST;
      torque_due_q.delete();
      fail_count_o   <= 0;
      pending_o      <= 0;
    end else begin
      // register writes and read-back
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (cfg_reg_e'(paddr[2]))
            REG_VOLTAGE_BASE: voltage_base_q <= pwdata[VOLT_W-1:0];
            REG_SPEED_BASE:   speed_base_q   <= pwdata[SPEED_W-1:0];
            default: ;
          endcase
        end else begin
          reg_value = (cfg_reg_e'(paddr[2]) == REG_VOLTAGE_BASE) ?
                      CFG_DATA_W'(voltage_base_q) : CFG_DATA_W'(speed_base_q);
          if (prdata !== reg_value) begin
            $error("prdata: expected %0d, actual %0d", reg_value, prdata);
            fails++;
          end
        end
      end

      // result transaction against the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (torque_due_q.size() == 0) begin
          $error("torque: expected none, actual %0d", torque_i);
          fails++;
        end else begin
          due = torque_due_q.pop_front();
          if (torque_i !== due) begin
            $error("torque: expected %0d, actual %0d", due, torque_i);
            fails++;
          end
        end
      end

      // input transaction: load updates the grid, query predicts a torque
      if (in_valid_i && !in_stall_i) begin
        if (action_e'(action_i) == ACT_LOAD) begin
          if (entry_row_i < GRID_ROWS && entry_column_i < GRID_COLS)
            torque_grid_q[entry_row_i*GRID_COLS + entry_column_i] = entry_value_i;
        end else begin
          torque_due_q.push_back(interpolate_torque(voltage_i, speed_i));
        end
      end
      fail_count_o <= fails;
      pending_o    <= torque_due_q.size();
    end
  end

endmodule

/* dv/torque_map_bilinear_lookup_tb.sv */
// Test top for the torque map bilinear lookup: clock, reset, stimulus and verdict.
// Depends on tmbl_pkg, the block under test and torque_map_bilinear_lookup_checker.
module torque_map_bilinear_lookup_tb;
  import tmbl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned GRID_ROWS    = 26;
  localparam int unsigned GRID_COLS    = 26;
  localparam int unsigned VOLT_STEP    = 5;
  localparam int unsigned SPEED_STEP   = 160;
  localparam int unsigned VOLT_SPAN    = (GRID_COLS - 1) * VOLT_STEP;
  localparam int unsigned SPEED_SPAN   = (GRID_ROWS - 1) * SPEED_STEP;
  localparam int unsigned VOLT_MAX     = (2 ** VOLT_W) - 1;
  localparam int unsigned SPEED_MAX    = (2 ** SPEED_W) - 1;
  localparam int unsigned IDX_MAX      = (2 ** IDX_W) - 1;
  localparam int unsigned PHASE_ITEMS  = 165;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel, penable, pwrite, pready;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic                  in_valid_i, in_stall_o;
  logic                  action_i;
  logic [VOLT_W-1:0]     voltage_i;
  logic [SPEED_W-1:0]    speed_i;
  logic [IDX_W-1:0]      entry_row_i, entry_column_i;
  logic [TQ_W-1:0]       entry_value_i;
  logic                  out_valid_o, out_stall_i;
  logic [TQ_W-1:0]       torque_o;
  int unsigned           fail_count, pending;

  // tb copy of the bases, used to aim queries at the grid
  int unsigned volt_base_now, speed_base_now;
  int unsigned burst_left;

  torque_map_bilinear_lookup #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .VOLT_STEP (VOLT_STEP),
    .SPEED_STEP(SPEED_STEP)
  ) dut (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_o, .action_i, .voltage_i, .speed_i,
    .entry_row_i, .entry_column_i, .entry_value_i,
    .out_valid_o, .out_stall_i, .torque_o
  );

  torque_map_bilinear_lookup_checker #(
    .GRID_ROWS (GRID_ROWS),
    .GRID_COLS (GRID_COLS),
    .VOLT_STEP (VOLT_STEP),
    .SPEED_STEP(SPEED_STEP)
  ) checker_i (
    .clk_i, .rst_ni,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .voltage_i, .speed_i,
    .entry_row_i, .entry_column_i, .entry_value_i,
    .out_valid_i(out_valid_o), .out_stall_i, .torque_i(torque_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Regression FAIL");
    $finish;
  end

  // receiver stall: modes from free-flowing to heavy back-pressure
  initial begin
    int unsigned mode, span, tick;
    out_stall_i = 1'b0;
    forever begin
      mode = $urandom_range(3, 0);
      span = $urandom_range(300, 20);
      for (tick = 0; tick < span; tick++) begin
        @(negedge clk_i);
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(1, 0) == 1);
          2: out_stall_i <= ($urandom_range(9, 0) < 8);
          default: out_stall_i <= ((tick % 4) == 3);
        endcase
      end
    end
  end

  // one register write, setup then access
  task automatic cfg_write(input cfg_reg_e idx, input int unsigned value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    pwdata  <= CFG_DATA_W'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one register read; the checker compares prdata
  task automatic cfg_read(input cfg_reg_e idx);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(int'(idx) * 4);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // one input transaction, with random bursts and gaps before it
  task automatic send_item(input action_e act, input int unsigned voltage,
                           input int unsigned speed, input int unsigned row,
                           input int unsigned col, input int unsigned value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
      if (gap > 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(24, 1);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    voltage_i      <= VOLT_W'(voltage);
    speed_i        <= SPEED_W'(speed);
    entry_row_i    <= IDX_W'(row);
    entry_column_i <= IDX_W'(col);
    entry_value_i  <= TQ_W'(value);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // unused fields of each kind carry random noise
  task automatic send_query(input int unsigned voltage, input int unsigned speed);
    send_item(ACT_QUERY, voltage, speed, $urandom_range(IDX_MAX, 0),
              $urandom_range(IDX_MAX, 0), $urandom_range(TQ_MAX, 0));
  endtask

  task automatic send_load(input int unsigned row, input int unsigned col,
                           input int unsigned value);
    send_item(ACT_LOAD, $urandom_range(VOLT_MAX, 0), $urandom_range(SPEED_MAX, 0),
              row, col, value);
  endtask

  // stop input, wait for every torque and for loads still in flight
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_bases(input int unsigned vbase, input int unsigned sbase);
    cfg_write(REG_VOLTAGE_BASE, vbase);
    cfg_write(REG_SPEED_BASE, sbase);
    cfg_read(REG_VOLTAGE_BASE);
    cfg_read(REG_SPEED_BASE);
    volt_base_now  = vbase;
    speed_base_now = sbase;
  endtask

  // pick a coordinate: near the grid, exactly on a grid point, or anywhere
  function automatic int unsigned pick_axis(input int unsigned base, input int unsigned step,
                                            input int unsigned span, input int unsigned limit);
    int unsigned lo, hi, v, margin;
    margin = 2 * step;
    case ($urandom_range(9, 0))
      0, 1: begin
        v = base + $urandom_range(span / step, 0) * step;
        return (v > limit) ? limit : v;
      end
      2, 3: return $urandom_range(limit, 0);
      default: begin
        lo = (base > margin) ? base - margin : 0;
        hi = (base + span + margin > limit) ? limit : base + span + margin;
        return $urandom_range(hi, lo);
      end
    endcase
  endfunction

  // mixed random traffic, mostly queries
  task automatic random_traffic(input int unsigned count);
    int unsigned n, kind, value;
    for (n = 0; n < count; n++) begin
      kind = $urandom_range(19, 0);
      if (kind < 14) begin
        send_query(pick_axis(volt_base_now, VOLT_STEP, VOLT_SPAN, VOLT_MAX),
                   pick_axis(speed_base_now, SPEED_STEP, SPEED_SPAN, SPEED_MAX));
      end else if (kind < 19) begin
        case ($urandom_range(5, 0))
          0: value = 0;
          1: value = TQ_MAX;
          default: value = $urandom_range(TQ_MAX, 0);
        endcase
        send_load($urandom_range(GRID_ROWS - 1, 0), $urandom_range(GRID_COLS - 1, 0), value);
      end else begin
        // index may be past the grid, then the load is dropped
        send_load($urandom_range(IDX_MAX, 0), $urandom_range(IDX_MAX, 0),
                  $urandom_range(TQ_MAX, 0));
      end
    end
  endtask

  // main sequence
  initial begin
    int unsigned r, c, p;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    action_i       = ACT_QUERY;
    voltage_i      = '0;
    speed_i        = '0;
    entry_row_i    = '0;
    entry_column_i = '0;
    entry_value_i  = '0;
    burst_left     = 0;
    volt_base_now  = VOLTAGE_BASE_RST;
    speed_base_now = SPEED_BASE_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset values read back
    cfg_read(REG_VOLTAGE_BASE);
    cfg_read(REG_SPEED_BASE);

    // every entry loaded first; (r + c) % 7 of 0 or 1 gives the value extremes
    for (r = 0; r < GRID_ROWS; r++)
      for (c = 0; c < GRID_COLS; c++)
        send_load(r, c, ((r + c) % 7 == 0) ? TQ_MAX :
                        ((r + c) % 7 == 1) ? 0 : $urandom_range(TQ_MAX, 0));

    // exactly on base, below, above, on and just under the last grid point
    send_query(VOLTAGE_BASE_RST, SPEED_BASE_RST);
    send_query(0, 0);
    send_query(VOLT_MAX, SPEED_MAX);
    send_query(VOLTAGE_BASE_RST + VOLT_SPAN, SPEED_BASE_RST + SPEED_SPAN);
    send_query(VOLTAGE_BASE_RST + VOLT_SPAN - 1, SPEED_BASE_RST + SPEED_SPAN - 1);
    send_query(VOLTAGE_BASE_RST + 2, SPEED_BASE_RST + 80);
    send_query(VOLTAGE_BASE_RST + VOLT_SPAN, SPEED_BASE_RST);
    send_query(VOLTAGE_BASE_RST, SPEED_BASE_RST + SPEED_SPAN);

    // loads past the grid are dropped
    send_load(GRID_ROWS, 0, TQ_MAX);
    send_load(0, GRID_COLS, TQ_MAX);
    send_load(IDX_MAX, IDX_MAX, TQ_MAX);

    // full-scale cell, then an all-zero cell, queried inside
    for (r = 3; r < 5; r++)
      for (c = 7; c < 9; c++)
        send_load(r, c, TQ_MAX);
    send_query(VOLTAGE_BASE_RST + 7 * VOLT_STEP + 2, SPEED_BASE_RST + 3 * SPEED_STEP + 77);
    for (r = 3; r < 5; r++)
      for (c = 7; c < 9; c++)
        send_load(r, c, 0);
    send_query(VOLTAGE_BASE_RST + 7 * VOLT_STEP + 2, SPEED_BASE_RST + 3 * SPEED_STEP + 77);

    random_traffic(PHASE_ITEMS);

    // base settings: extremes first, then random
    for (p = 0; p < 7; p++) begin
      drain();
      case (p)
        0: set_bases(0, 0);
        1: set_bases(VOLT_MAX, SPEED_MAX);
        2: set_bases(VOLT_MAX, 0);
        3: set_bases(0, SPEED_MAX);
        default: set_bases($urandom_range(VOLT_MAX, 0), $urandom_range(SPEED_MAX, 0));
      endcase
      random_traffic(PHASE_ITEMS);
    end

    drain();
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* sim.f */
src/tmbl_pkg.sv
src/tmbl_cdiv.sv
src/torque_map_bilinear_lookup.sv
dv/torque_map_bilinear_lookup_checker.sv
dv/torque_map_bilinear_lookup_tb.sv
